FILE: hw/rtl/lpcb_pkg.sv
// shared types, register codes and constants of the layer pixel compositor
package lpcb_pkg;

  // one candidate layer pixel as it arrives from the renderer
  typedef struct packed {
    logic        has_layer;
    logic [14:0] layer_color;
    logic [1:0]  layer_priority;
    logic [2:0]  layer_source;
    logic        layer_transparent;
    logic        layer_semi;
    logic        effects_enabled;
    logic        last_of_dot;
  } in_item_t;

  // one finished dot
  typedef struct packed {
    logic [14:0] out_color;
    logic [1:0]  applied_effect;
  } out_item_t;

  // kept pixel, same packing as the dot state: semi on top, color at the bottom
  typedef struct packed {
    logic        semi;
    logic        transparent;
    logic [2:0]  source;
    logic [1:0]  prio;
    logic [14:0] color;
  } pixel_t;

  // classified dot handed from the front part to the back part
  typedef struct packed {
    logic        use_backdrop;
    logic [14:0] top_color;
    logic [2:0]  top_source;
    logic        top_semi;
    logic        has_second;
    logic [14:0] second_color;
    logic [2:0]  second_source;
    logic        effects_enabled;
  } dot_t;

  // configuration registers
  typedef struct packed {
    logic [14:0] backdrop_color;
    logic        force_blank;
    logic [1:0]  effect_mode;
    logic [5:0]  first_target_mask;
    logic [5:0]  second_target_mask;
    logic [4:0]  blend_weight_a;
    logic [4:0]  blend_weight_b;
    logic [4:0]  brightness_weight;
  } cfg_t;

  // register indexes
  localparam logic [2:0] REG_BACKDROP_COLOR     = 3'd0;
  localparam logic [2:0] REG_FORCE_BLANK        = 3'd1;
  localparam logic [2:0] REG_EFFECT_MODE        = 3'd2;
  localparam logic [2:0] REG_FIRST_TARGET_MASK  = 3'd3;
  localparam logic [2:0] REG_SECOND_TARGET_MASK = 3'd4;
  localparam logic [2:0] REG_BLEND_WEIGHT_A     = 3'd5;
  localparam logic [2:0] REG_BLEND_WEIGHT_B     = 3'd6;
  localparam logic [2:0] REG_BRIGHTNESS_WEIGHT  = 3'd7;

  // effect codes
  localparam logic [1:0] EFFECT_NONE     = 2'd0;
  localparam logic [1:0] EFFECT_BLEND    = 2'd1;
  localparam logic [1:0] EFFECT_BRIGHTEN = 2'd2;
  localparam logic [1:0] EFFECT_DARKEN   = 2'd3;

  // source code of the backdrop
  localparam logic [2:0] SRC_BACKDROP = 3'd5;

  // color arithmetic constants
  localparam logic [14:0] WHITE      = 15'h7FFF;
  localparam logic [8:0]  FULL_SCALE = 9'h1F0;
  localparam logic [4:0]  WEIGHT_MAX = 5'h10;
  localparam logic [4:0]  CH_MAX     = 5'd31;

endpackage

FILE: hw/rtl/lpcb_front.sv
// front part: keeps the two best pixels of a dot and classifies the finished dot
module lpcb_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  lpcb_pkg::in_item_t item,
  input  logic              queue_full,
  output logic              push,
  output lpcb_pkg::dot_t    push_data
);

  lpcb_pkg::pixel_t front_pixel, front_pixel_next;
  lpcb_pkg::pixel_t behind_pixel, behind_pixel_next;
  logic             front_valid, front_valid_next;
  logic             behind_valid, behind_valid_next;
  lpcb_pkg::pixel_t new_pixel;
  logic             accept;

  // true if a ranks strictly ahead of b
  function automatic logic ranks_ahead(lpcb_pkg::pixel_t a, lpcb_pkg::pixel_t b);
    logic r;
    if (a.transparent != b.transparent) begin
      r = !a.transparent;
    end else if (a.prio != b.prio) begin
      r = a.prio < b.prio;
    end else begin
      r = a.source < b.source;
    end
    return r;
  endfunction

  assign item_ready = !queue_full;
  assign accept     = item_valid && item_ready;

  // incoming pixel
  always_comb begin
    new_pixel.semi        = item.layer_semi;
    new_pixel.transparent = item.layer_transparent;
    new_pixel.source      = item.layer_source;
    new_pixel.prio        = item.layer_priority;
    new_pixel.color       = item.layer_color;
  end

  // top-two insertion
  always_comb begin
    front_pixel_next  = front_pixel;
    front_valid_next  = front_valid;
    behind_pixel_next = behind_pixel;
    behind_valid_next = behind_valid;
    if (item.has_layer) begin
      if (!front_valid) begin
        front_pixel_next = new_pixel;
        front_valid_next = 1'b1;
      end else if (ranks_ahead(new_pixel, front_pixel)) begin
        behind_pixel_next = front_pixel;
        behind_valid_next = 1'b1;
        front_pixel_next  = new_pixel;
      end else if (!behind_valid || ranks_ahead(new_pixel, behind_pixel)) begin
        behind_pixel_next = new_pixel;
        behind_valid_next = 1'b1;
      end
    end
  end

  // classify the dot on its last word
  always_comb begin
    push                    = accept && item.last_of_dot;
    push_data.use_backdrop  = !front_valid_next || front_pixel_next.transparent;
    push_data.top_color     = front_pixel_next.color;
    push_data.top_source    = front_pixel_next.source;
    push_data.top_semi      = front_pixel_next.semi && !push_data.use_backdrop;
    push_data.has_second    = !push_data.use_backdrop && behind_valid_next
                              && !behind_pixel_next.transparent;
    push_data.second_color  = behind_pixel_next.color;
    push_data.second_source = behind_pixel_next.source;
    push_data.effects_enabled = item.effects_enabled;
  end

  // dot state
  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid  <= 1'b0;
      behind_valid <= 1'b0;
      front_pixel  <= '0;
      behind_pixel <= '0;
    end else if (accept) begin
      if (item.last_of_dot) begin
        front_valid  <= 1'b0;
        behind_valid <= 1'b0;
        front_pixel  <= '0;
        behind_pixel <= '0;
      end else begin
        front_valid  <= front_valid_next;
        behind_valid <= behind_valid_next;
        front_pixel  <= front_pixel_next;
        behind_pixel <= behind_pixel_next;
      end
    end
  end

endmodule

FILE: hw/rtl/lpcb_fifo.sv
// two-entry queue of classified dots between the front and back parts
module lpcb_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lpcb_pkg::dot_t push_data,
  input  logic           pop,
  output lpcb_pkg::dot_t pop_data,
  output logic           full,
  output logic           empty
);

  lpcb_pkg::dot_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full     = count == 2'd2;
  assign empty    = count == 2'd0;
  assign pop_data = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // no overflow, no underflow, count tracks pushes
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("dot queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("dot queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("dot queue count did not follow a push");

endmodule

FILE: hw/rtl/lpcb_back.sv
// back part: applies blend, brighten or darken, or white on force blank, and holds the result word
module lpcb_back (
  input  logic               clk,
  input  logic               rst,
  input  lpcb_pkg::cfg_t     cfg,
  input  lpcb_pkg::dot_t     dot,
  input  logic               dot_valid,
  output logic               dot_pop,
  output lpcb_pkg::out_item_t result,
  output logic               result_valid,
  input  logic               result_ready
);

  lpcb_pkg::out_item_t result_next;
  logic [14:0] top_color;
  logic [2:0]  top_source;
  logic        top_semi;
  logic [1:0]  effect;
  logic        first;
  logic        second;
  logic [4:0]  wa, wb, wy;

  function automatic logic in_mask(logic [5:0] mask, logic [2:0] src);
    logic r;
    r = 1'b0;
    if (src <= lpcb_pkg::SRC_BACKDROP) begin
      r = mask[src];
    end
    return r;
  endfunction

  function automatic logic [4:0] clamp_w(logic [4:0] w);
    return (w > lpcb_pkg::WEIGHT_MAX) ? lpcb_pkg::WEIGHT_MAX : w;
  endfunction

  function automatic logic [4:0] blend_ch(logic [4:0] a, logic [4:0] b,
                                          logic [4:0] wa_in, logic [4:0] wb_in);
    logic [9:0] sum;
    logic [5:0] v;
    sum = ({5'd0, wa_in} * {5'd0, a}) + ({5'd0, wb_in} * {5'd0, b});
    v   = sum[9:4];
    return (v > {1'b0, lpcb_pkg::CH_MAX}) ? lpcb_pkg::CH_MAX : v[4:0];
  endfunction

  function automatic logic [4:0] bright_ch(logic [4:0] c, logic [4:0] w);
    logic [8:0]  x;
    logic [8:0]  d;
    logic [12:0] p;
    logic [9:0]  s;
    x = {c, 4'd0};
    d = lpcb_pkg::FULL_SCALE - x;
    p = {4'd0, d} * {8'd0, w};
    s = {1'b0, x} + {1'b0, p[12:4]};
    return s[8:4];
  endfunction

  function automatic logic [4:0] dark_ch(logic [4:0] c, logic [4:0] w);
    logic [8:0]  x;
    logic [12:0] p;
    logic [8:0]  s;
    x = {c, 4'd0};
    p = {4'd0, x} * {8'd0, w};
    s = x - p[12:4];
    return s[8:4];
  endfunction

  assign dot_pop = dot_valid && (!result_valid || result_ready);

  // top pixel, effect choice and target tests
  always_comb begin
    top_color  = dot.use_backdrop ? cfg.backdrop_color : dot.top_color;
    top_source = dot.use_backdrop ? lpcb_pkg::SRC_BACKDROP : dot.top_source;
    top_semi   = dot.top_semi;
    if (top_semi && dot.has_second) begin
      effect = lpcb_pkg::EFFECT_BLEND;
    end else if (!dot.effects_enabled) begin
      effect = lpcb_pkg::EFFECT_NONE;
    end else begin
      effect = cfg.effect_mode;
    end
    first  = in_mask(cfg.first_target_mask, top_source);
    second = in_mask(cfg.second_target_mask, dot.second_source);
    wa     = clamp_w(cfg.blend_weight_a);
    wb     = clamp_w(cfg.blend_weight_b);
    wy     = clamp_w(cfg.brightness_weight);
  end

  // color arithmetic
  always_comb begin
    result_next.out_color      = top_color;
    result_next.applied_effect = lpcb_pkg::EFFECT_NONE;
    case (effect)
      lpcb_pkg::EFFECT_BLEND: begin
        if (dot.has_second && (first || top_semi) && second) begin
          result_next.out_color = {
            blend_ch(top_color[14:10], dot.second_color[14:10], wa, wb),
            blend_ch(top_color[9:5], dot.second_color[9:5], wa, wb),
            blend_ch(top_color[4:0], dot.second_color[4:0], wa, wb)};
          result_next.applied_effect = lpcb_pkg::EFFECT_BLEND;
        end
      end
      lpcb_pkg::EFFECT_BRIGHTEN: begin
        if (first) begin
          result_next.out_color = {bright_ch(top_color[14:10], wy),
                                   bright_ch(top_color[9:5], wy),
                                   bright_ch(top_color[4:0], wy)};
          result_next.applied_effect = lpcb_pkg::EFFECT_BRIGHTEN;
        end
      end
      lpcb_pkg::EFFECT_DARKEN: begin
        if (first) begin
          result_next.out_color = {dark_ch(top_color[14:10], wy),
                                   dark_ch(top_color[9:5], wy),
                                   dark_ch(top_color[4:0], wy)};
          result_next.applied_effect = lpcb_pkg::EFFECT_DARKEN;
        end
      end
      default: begin
      end
    endcase
    if (cfg.force_blank) begin
      result_next.out_color      = lpcb_pkg::WHITE;
      result_next.applied_effect = lpcb_pkg::EFFECT_NONE;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (dot_pop) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dot_pop) begin
      result <= result_next;
    end
  end

endmodule

FILE: hw/rtl/layer_pixel_compositor_blend_top.sv
// top level of the layer pixel compositor: register port, front, queue and back
// The compositor takes one candidate layer pixel word per clock cycle, stalling
// only while the queue is full, and keeps the best two pixels of the current dot
// in the front part; the word marked last of dot hands the classified dot to a
// two-entry queue, and the back part, while its output is taken, turns one queued
// dot per cycle into a BGR555 color in its output register. Sustained rate is one
// word per cycle when nothing stalls; the ranking compare and the blend arithmetic
// are combinational. A result word is loaded into the output register as the back
// part pops its dot. Configuration registers sit at byte addresses 0 to 28, and the
// user writes them only while the block is idle; the block does not enforce it.
module layer_pixel_compositor_blend_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  lpcb_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output lpcb_pkg::out_item_t result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  lpcb_pkg::cfg_t cfg;
  lpcb_pkg::dot_t push_data, pop_data;
  logic           push, pop, full, empty;
  logic           cfg_write;
  logic [2:0]     reg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[4:2];

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (reg_index)
        lpcb_pkg::REG_BACKDROP_COLOR:     cfg.backdrop_color     <= pwdata[14:0];
        lpcb_pkg::REG_FORCE_BLANK:        cfg.force_blank        <= pwdata[0];
        lpcb_pkg::REG_EFFECT_MODE:        cfg.effect_mode        <= pwdata[1:0];
        lpcb_pkg::REG_FIRST_TARGET_MASK:  cfg.first_target_mask  <= pwdata[5:0];
        lpcb_pkg::REG_SECOND_TARGET_MASK: cfg.second_target_mask <= pwdata[5:0];
        lpcb_pkg::REG_BLEND_WEIGHT_A:     cfg.blend_weight_a     <= pwdata[4:0];
        lpcb_pkg::REG_BLEND_WEIGHT_B:     cfg.blend_weight_b     <= pwdata[4:0];
        lpcb_pkg::REG_BRIGHTNESS_WEIGHT:  cfg.brightness_weight  <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    prdata = '0;
    unique case (reg_index)
      lpcb_pkg::REG_BACKDROP_COLOR:     prdata = {17'd0, cfg.backdrop_color};
      lpcb_pkg::REG_FORCE_BLANK:        prdata = {31'd0, cfg.force_blank};
      lpcb_pkg::REG_EFFECT_MODE:        prdata = {30'd0, cfg.effect_mode};
      lpcb_pkg::REG_FIRST_TARGET_MASK:  prdata = {26'd0, cfg.first_target_mask};
      lpcb_pkg::REG_SECOND_TARGET_MASK: prdata = {26'd0, cfg.second_target_mask};
      lpcb_pkg::REG_BLEND_WEIGHT_A:     prdata = {27'd0, cfg.blend_weight_a};
      lpcb_pkg::REG_BLEND_WEIGHT_B:     prdata = {27'd0, cfg.blend_weight_b};
      lpcb_pkg::REG_BRIGHTNESS_WEIGHT:  prdata = {27'd0, cfg.brightness_weight};
      default: prdata = '0;
    endcase
  end

  // pixel ranking and dot classification
  lpcb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .queue_full (full),
    .push       (push),
    .push_data  (push_data)
  );

  // dot queue
  lpcb_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  // color effects and result register
  lpcb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .dot          (pop_data),
    .dot_valid    (!empty),
    .dot_pop      (pop),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule
